// File: rtl/bst_pkg.sv
package bst_pkg;

  // Default geometry
  localparam int unsigned DEF_CAPACITY     = 16;
  localparam int unsigned DEF_ELEMENT_BITS = 32;

  // Fixed port widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic cmp;  // capture match flag
    logic ins;  // write request value at the tail slot
    logic del;  // shift entries at and after the hit down one place
  } cell_ctl_t;

endpackage

// File: rtl/bst_cell.sv
module bst_cell import bst_pkg::*; #(
  parameter int unsigned ELEMENT_BITS = DEF_ELEMENT_BITS,
  parameter int unsigned CNT_W        = COUNT_W,
  parameter int unsigned IDX          = 0
) (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic [ELEMENT_BITS-1:0] value,
  input  logic [CNT_W-1:0]        count,
  input  logic                    prefix_in,
  input  logic [ELEMENT_BITS-1:0] next_entry,
  output logic [ELEMENT_BITS-1:0] entry,
  output logic                    hit,
  output logic                    prefix_out
);

  logic [ELEMENT_BITS-1:0] entry_r, entry_nxt;
  logic                    hit_r, hit_nxt;
  logic                    slot_valid;
  logic                    is_tail;

  // Occupancy follows from the shared count
  assign slot_valid = (CNT_W'(IDX) < count);
  assign is_tail    = (CNT_W'(IDX) == count);

  // Match against the request value
  assign hit_nxt = ctl.cmp ? (slot_valid && (entry_r == value)) : hit_r;

  // A hit at or before this slot pulls the neighbor down
  assign prefix_out = prefix_in | hit_r;

  // Entry update
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins && is_tail) begin
      entry_nxt = value;
    end else if (ctl.del && prefix_out) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    hit_r   <= hit_nxt;
  end

  assign entry = entry_r;
  assign hit   = hit_r;

endmodule

// File: rtl/bounded_set_table.sv
// Bounded set table: a set of up to CAPACITY distinct values kept as a packed
// list in a row of cells, one entry per cell.
// Input channel (in_valid/in_ready): one request of kind clear, insert, delete
// or query, with the value to look up. Value bits above ELEMENT_BITS are
// ignored.
// Result channel (out_valid/out_ready): one result per request with the prior
// membership, whether the set changed, the new count, and empty/full flags.
// Each request passes through a compare state (ST_CMP), in which every cell
// compares its entry with the value in parallel, and then an update state
// (ST_UPD), in which the hits are combined and the cells update (tail write on
// insert, shift-down chain on delete) as the result is registered.
// The next request is accepted in the update cycle, while the previous result
// may still sit in the output register.
// When the receiver stalls, the finished result holds in the output register;
// a following request is compared but not applied until that slot frees.
// Reset (rst_n low, synchronous) empties the set and drops any request in
// flight; entry storage is not cleared, the count alone marks live entries.
module bounded_set_table import bst_pkg::*; #(
  parameter int unsigned CAPACITY     = DEF_CAPACITY,
  parameter int unsigned ELEMENT_BITS = DEF_ELEMENT_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_was_member,
  output logic               out_changed,
  output logic [COUNT_W-1:0] out_entry_count,
  output logic               out_is_empty,
  output logic               out_is_full
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  state_t                  state_r, state_nxt;
  kind_t                   kind_r;
  logic [ELEMENT_BITS-1:0] value_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    was_member_r, changed_r, is_empty_r, is_full_r;
  logic [COUNT_W-1:0]      entry_count_r;

  logic                    accept;
  logic                    commit;
  logic                    member;
  logic                    changed;
  logic                    ins_ok;
  logic                    del_ok;
  cell_ctl_t               ctl;
  logic [CAPACITY-1:0]     hit_vec;
  logic [CAPACITY:0]       prefix;
  logic [ELEMENT_BITS-1:0] entry_vec [CAPACITY];
  logic [ELEMENT_BITS+VALUE_W-1:0] value_ext;
  logic [CNT_W+COUNT_W-1:0]        count_ext;

  // Handshake
  assign commit   = (state_r == ST_UPD) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ST_IDLE) || commit;
  assign accept   = in_valid && in_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD: begin
        if (commit) begin
          state_nxt = in_valid ? ST_CMP : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Cell control outputs
  assign member = |hit_vec;
  assign ins_ok = (kind_r == KIND_INSERT) && !member && (count_r < CNT_W'(CAPACITY));
  assign del_ok = (kind_r == KIND_DELETE) && member;

  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_IDLE: ctl = '0;
      ST_CMP:  ctl.cmp = 1'b1;
      ST_UPD: begin
        ctl.ins = commit && ins_ok;
        ctl.del = commit && del_ok;
      end
      default: ctl = '0;
    endcase
  end

  // Count update and change flag
  always_comb begin
    count_nxt = count_r;
    changed   = 1'b0;
    unique case (kind_r)
      KIND_CLEAR: begin
        changed   = (count_r != '0);
        count_nxt = '0;
      end
      KIND_INSERT: begin
        changed = ins_ok;
        if (ins_ok) count_nxt = count_r + CNT_W'(1);
      end
      KIND_DELETE: begin
        changed = del_ok;
        if (del_ok) count_nxt = count_r - CNT_W'(1);
      end
      KIND_QUERY: changed = 1'b0;
      default:    changed = 1'b0;
    endcase
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) count_r <= count_nxt;
    end
  end

  assign value_ext = {{ELEMENT_BITS{1'b0}}, in_value};

  // Request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= kind_t'(in_kind);
      value_r <= value_ext[ELEMENT_BITS-1:0];
    end
    if (commit) begin
      was_member_r  <= member;
      changed_r     <= changed;
      entry_count_r <= count_ext[COUNT_W-1:0];
      is_empty_r    <= (count_nxt == '0);
      is_full_r     <= (count_nxt == CNT_W'(CAPACITY));
    end
  end

  // Row of cells
  assign prefix[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEMENT_BITS-1:0] next_entry;
    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = entry_vec[i];
    end else begin : g_mid
      assign next_entry = entry_vec[i+1];
    end

    bst_cell #(
      .ELEMENT_BITS (ELEMENT_BITS),
      .CNT_W        (CNT_W),
      .IDX          (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .value      (value_r),
      .count      (count_r),
      .prefix_in  (prefix[i]),
      .next_entry (next_entry),
      .entry      (entry_vec[i]),
      .hit        (hit_vec[i]),
      .prefix_out (prefix[i+1])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_was_member  = was_member_r;
  assign out_changed     = changed_r;
  assign out_entry_count = entry_count_r;
  assign out_is_empty    = is_empty_r;
  assign out_is_full     = is_full_r;

endmodule
